// ===== src/nbbt_pkg.sv =====
// Shared types and constants for the NAND bad block table.
`default_nettype none
package nbbt_pkg;

  localparam int unsigned WORD_W   = 32;  // bitmap bits per RAM row
  localparam int unsigned BIT_W    = 5;   // index of a bit inside a row
  localparam int unsigned BLK_W    = 12;
  localparam int unsigned GOOD_W   = 11;
  localparam int unsigned CNT_OUT_W = 12;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 12;

  localparam logic [7:0]  MARKER_ERASED    = 8'hFF;
  localparam int unsigned GOOD_INDEX_LIMIT = 2048;
  localparam logic [12:0] COUNT_MAX        = 13'd4095;

  localparam logic [2:0] OP_SCAN  = 3'd0;
  localparam logic [2:0] OP_MARK  = 3'd1;
  localparam logic [2:0] OP_QUERY = 3'd2;
  localparam logic [2:0] OP_COUNT = 3'd3;
  localparam logic [2:0] OP_FIND  = 3'd4;

  localparam logic [CFG_AW-1:0] CFG_WIN_LOW  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_WIN_HIGH = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_START    = 2'd2;

  localparam logic [11:0] WIN_LOW_RST  = 12'd0;
  localparam logic [11:0] WIN_HIGH_RST = 12'd2047;
  localparam logic [10:0] START_RST    = 11'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] block;
    logic [7:0]  main_byte;
    logic [7:0]  spare_byte;
    logic        read_ok;
  } in_t;

  typedef struct packed {
    logic        is_bad;
    logic        write_marker;
    logic        found;
    logic [10:0] good_block;
    logic [11:0] bad_count;
  } out_t;

endpackage
`default_nettype wire

// ===== src/nbbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nbbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/nand_bad_block_table_core.sv =====
// Top level of the NAND bad block table: bitmap RAM, command sequencer, counters.
//
//  channel | ports                        | dir | handshake
//  --------+------------------------------+-----+-------------------------------
//  in      | in_valid, in_stall, in_data  | in  | transfer on valid & !stall
//  out     | out_valid, out_stall, out_data| out | transfer on valid & !stall
//  cfg     | cfg_we, cfg_addr, cfg_wdata  | in  | write on cfg_we
//
//  Scan, mark, query, count: the command is decoded in ST_EXEC and its result is
//  offered in ST_OUT; once the result transfers, the FSM returns to ST_IDLE.
//  Find-first-good walks the bitmap in ST_SEARCH in between, one 32-bit row at a time,
//  at most ceil(min(BLOCK_COUNT, 2048)/32) rows, none when the range is empty.
//  One command at a time; in_stall is high until the result has transferred.
//  Synchronous reset; bitmap rows carry valid flops, so no clearing pass.
`default_nettype none
module nand_bad_block_table_core #(
  parameter int unsigned BLOCK_COUNT = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire nbbt_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output nbbt_pkg::out_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic [nbbt_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [nbbt_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int unsigned WORD_W = nbbt_pkg::WORD_W;
  localparam int unsigned BIT_W  = nbbt_pkg::BIT_W;
  localparam int unsigned ROWS   = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CNT_W  = $clog2(BLOCK_COUNT + 1);
  localparam int unsigned LIMIT  = (BLOCK_COUNT < nbbt_pkg::GOOD_INDEX_LIMIT) ?
                                   BLOCK_COUNT : nbbt_pkg::GOOD_INDEX_LIMIT;

  nbbt_pkg::state_t state_r, state_nxt;
  nbbt_pkg::in_t    item_r;
  nbbt_pkg::out_t   res_r, res_nxt;

  logic [11:0]      win_low_r, win_high_r;
  logic [10:0]      start_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ROWS-1:0]  vld_r, vld_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [11:0]      last_idx_r, last_idx_nxt;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // decode
  logic              in_rng, in_win, old_bit, scan_bad;
  logic [ROW_W-1:0]  item_row, start_row, last_row;
  logic [BIT_W-1:0]  item_bit, lo_bit, hi_bit, hit_pos;
  logic [WORD_W-1:0] item_word, scan_word, mask, free_bits;
  logic [11:0]       end_idx, start_ext;
  logic              find_go, hit, last_hit;
  logic [12:0]       cnt_ext;

  nbbt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    in_rng    = {1'b0, item_r.block} < 13'(BLOCK_COUNT);
    in_win    = (item_r.block >= win_low_r) && (item_r.block <= win_high_r);
    scan_bad  = item_r.read_ok && ((item_r.main_byte != nbbt_pkg::MARKER_ERASED) ||
                                   (item_r.spare_byte != nbbt_pkg::MARKER_ERASED));
    item_row  = item_r.block[BIT_W +: ROW_W];
    item_bit  = item_r.block[BIT_W-1:0];
    item_word = vld_r[item_row] ? ram_rdata : '0;
    old_bit   = item_word[item_bit];

    end_idx   = (win_high_r > 12'(LIMIT)) ? 12'(LIMIT) : win_high_r;
    start_ext = {1'b0, start_r};
    start_row = start_ext[BIT_W +: ROW_W];
    find_go   = (state_r == nbbt_pkg::ST_EXEC) && (item_r.opcode == nbbt_pkg::OP_FIND) &&
                (start_ext < end_idx);

    // search window inside the current row
    last_row  = last_idx_r[BIT_W +: ROW_W];
    lo_bit    = (cur_row_r == start_row) ? start_r[BIT_W-1:0] : '0;
    hi_bit    = (cur_row_r == last_row) ? last_idx_r[BIT_W-1:0] : BIT_W'(WORD_W - 1);
    mask      = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
    scan_word = vld_r[cur_row_r] ? ram_rdata : '0;
    free_bits = ~scan_word & mask;
    hit       = |free_bits;
    last_hit  = (cur_row_r == last_row);
    hit_pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_pos = BIT_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nbbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nbbt_pkg::ST_EXEC;
        end
      end
      nbbt_pkg::ST_EXEC: begin
        state_nxt = find_go ? nbbt_pkg::ST_SEARCH : nbbt_pkg::ST_OUT;
      end
      nbbt_pkg::ST_SEARCH: begin
        if (hit || last_hit) begin
          state_nxt = nbbt_pkg::ST_OUT;
        end
      end
      nbbt_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = nbbt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nbbt_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    logic new_bit;
    logic wr;
    new_bit      = old_bit;
    wr           = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = item_row;
    ram_wdata    = item_word;
    ram_raddr    = in_data.block[BIT_W +: ROW_W];
    res_nxt      = res_r;
    cnt_nxt      = cnt_r;
    vld_nxt      = vld_r;
    cur_row_nxt  = cur_row_r;
    last_idx_nxt = last_idx_r;
    unique case (state_r)
      nbbt_pkg::ST_EXEC: begin
        if (in_rng) begin
          if (item_r.opcode == nbbt_pkg::OP_SCAN) begin
            new_bit = in_win && scan_bad;
          end else if (item_r.opcode == nbbt_pkg::OP_MARK && !old_bit) begin
            new_bit = 1'b1;
            wr      = 1'b1;
          end
        end
        if (in_rng && (new_bit != old_bit)) begin
          ram_we              = 1'b1;
          ram_wdata[item_bit] = new_bit;
          vld_nxt[item_row]   = 1'b1;
          cnt_nxt             = new_bit ? cnt_r + 1'b1 : cnt_r - 1'b1;
        end
        cnt_ext              = 13'(cnt_nxt);
        res_nxt.is_bad       = in_rng ? new_bit : 1'b1;
        res_nxt.write_marker = wr;
        res_nxt.found        = 1'b0;
        res_nxt.good_block   = '0;
        res_nxt.bad_count    = (cnt_ext > nbbt_pkg::COUNT_MAX) ?
                               nbbt_pkg::COUNT_MAX[11:0] : cnt_ext[11:0];
        if (find_go) begin
          ram_raddr    = start_row;
          cur_row_nxt  = start_row;
          last_idx_nxt = end_idx - 12'd1;
        end
      end
      nbbt_pkg::ST_SEARCH: begin
        cnt_ext = 13'(cnt_r);
        if (hit) begin
          res_nxt.found      = 1'b1;
          res_nxt.good_block = 11'({cur_row_r, hit_pos});
        end else if (!last_hit) begin
          cur_row_nxt = cur_row_r + 1'b1;
          ram_raddr   = cur_row_r + 1'b1;
        end
      end
      nbbt_pkg::ST_IDLE, nbbt_pkg::ST_OUT: begin
        cnt_ext = 13'(cnt_r);
      end
      default: begin
        cnt_ext = 13'(cnt_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= nbbt_pkg::ST_IDLE;
      cnt_r      <= '0;
      vld_r      <= '0;
      win_low_r  <= nbbt_pkg::WIN_LOW_RST;
      win_high_r <= nbbt_pkg::WIN_HIGH_RST;
      start_r    <= nbbt_pkg::START_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          nbbt_pkg::CFG_WIN_LOW:  win_low_r  <= cfg_wdata;
          nbbt_pkg::CFG_WIN_HIGH: win_high_r <= cfg_wdata;
          nbbt_pkg::CFG_START:    start_r    <= cfg_wdata[10:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == nbbt_pkg::ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    res_r      <= res_nxt;
    cur_row_r  <= cur_row_nxt;
    last_idx_r <= last_idx_nxt;
  end

  assign in_stall  = !rst_n || (state_r != nbbt_pkg::ST_IDLE);
  assign out_valid = rst_n && (state_r == nbbt_pkg::ST_OUT);
  assign out_data  = res_r;

endmodule
`default_nettype wire

// ===== src/nbbt_checker.sv =====
// Port-level checker for the NAND bad block table, bound to the top level.
`default_nettype none
module nbbt_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire nbbt_pkg::out_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one command at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in flight");

  // no new input while a result is pending
  a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while result pending");

  a_marker_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_marker |-> out_data.is_bad && !out_data.found)
    else $error("marker write on a block not flagged bad");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.good_block == '0)
    else $error("good_block set without found");

endmodule

bind nand_bad_block_table_core nbbt_checker u_nbbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
